>>> sv/led_strip_event_animator_macros.svh
// Assertion macros shared by the animator. They expect clk and arst_n in scope.
`ifndef LED_STRIP_EVENT_ANIMATOR_MACROS_SVH
`define LED_STRIP_EVENT_ANIMATOR_MACROS_SVH
`ifndef SYNTH
`define LSEA_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("animator assertion failed");
`define LSEA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("animator assertion failed");
`else
`define LSEA_ASSERT_IMPLY(label, ante, cons)
`define LSEA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/lsea_pkg.sv
`default_nettype none
package lsea_pkg;

	localparam int LED_COUNT = 4;
	localparam int PIX_W = 6;
	localparam int TIME_W = 32;
	localparam int COLOR_W = 24;
	localparam int KIND_W = 3;
	localparam int CFG_IDX_W = 1;
	localparam int DUR_W = 11;
	localparam int TDT_W = 11;

	localparam logic [TIME_W-1:0] FRAME_GAP_MS = 32'd40;

	localparam int BREATH_MS = 4000;
	localparam int SEARCH_MS = 220;
	localparam int SEARCH_MOD = SEARCH_MS * LED_COUNT;
	localparam int DIV_MAX = (SEARCH_MOD > BREATH_MS) ? SEARCH_MOD : BREATH_MS;
	localparam int REM_W = $clog2(DIV_MAX) + 1;
	localparam logic [REM_W-1:0] SEARCH_DIV = REM_W'(SEARCH_MOD);
	localparam logic [REM_W-1:0] BREATH_DIV = REM_W'(BREATH_MS);
	localparam int DIV_BITS = 4;
	localparam int DIV_STEPS = TIME_W / DIV_BITS;
	localparam int DSTEP_W = $clog2(DIV_STEPS);

	localparam int BOOT_MUL = LED_COUNT + 2;
	localparam int BOOT_MUL_W = $clog2(BOOT_MUL + 1);
	localparam int HEAD_W = PIX_W + 1;

	localparam int CAP_RECIP = 437;
	localparam int CAP_SHIFT = 15;
	localparam int DEAUTH_RECIP = 205;
	localparam int DEAUTH_SHIFT = 10;
	localparam int FRIEND_RECIP = 29960;
	localparam int FRIEND_SHIFT = 20;
	localparam int FIX_RECIP = 33555;
	localparam int FIX_SHIFT = 22;
	localparam int BOOT_RECIP = 11185;
	localparam int BOOT_SHIFT = 22;
	localparam int SEARCH_RECIP = 4767;
	localparam int SEARCH_SHIFT = 18;
	localparam int BREATH_RECIP = 33555;
	localparam int BREATH_SHIFT = 22;

	localparam logic [COLOR_W-1:0] MOOD_RESET = 24'h100018;
	localparam logic [COLOR_W-1:0] COLOR_CAPTURE = 24'h00DC28;
	localparam logic [COLOR_W-1:0] COLOR_DEAUTH = 24'hFF0C0C;
	localparam logic [COLOR_W-1:0] COLOR_SEARCH = 24'hFF7800;
	localparam logic [7:0] FRIEND_RED = 8'd20;
	localparam logic [7:0] FRIEND_GREEN = 8'd60;
	localparam logic [7:0] BOOT_HEAD_RED = 8'd220;
	localparam logic [7:0] BOOT_SIDE_RED = 8'd140;
	localparam logic [7:0] LUM_BASE = 8'd90;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [5:0] COS_QUARTER [65] = '{
		6'd38, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38,
		6'd38, 6'd37, 6'd37, 6'd37, 6'd37, 6'd36, 6'd36, 6'd36,
		6'd35, 6'd35, 6'd35, 6'd34, 6'd34, 6'd33, 6'd33, 6'd32,
		6'd32, 6'd31, 6'd31, 6'd30, 6'd30, 6'd29, 6'd28, 6'd28,
		6'd27, 6'd26, 6'd26, 6'd25, 6'd24, 6'd24, 6'd23, 6'd22,
		6'd21, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17, 6'd16, 6'd16,
		6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9, 6'd8,
		6'd7, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1,
		6'd0
	};

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_EVENT = 1'b1
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		EV_CAPTURE = 3'd0,
		EV_DEAUTH = 3'd1,
		EV_FRIEND = 3'd2,
		EV_SEARCH = 3'd3,
		EV_FIX = 3'd4,
		EV_BOOT = 3'd5
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LED_ENABLE = 1'b0,
		REG_MOOD_COLOR = 1'b1
	} reg_t;

	typedef struct packed {
		logic run;
		kind_t kind;
		logic [TIME_W-1:0] dt;
		logic [TIME_W-1:0] now;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [DUR_W-1:0] event_duration(kind_t kind);
		logic [DUR_W-1:0] dur;
		case (kind)
			EV_CAPTURE: dur = 11'd900;
			EV_DEAUTH: dur = 11'd1200;
			EV_FRIEND: dur = 11'd700;
			EV_FIX: dur = 11'd1000;
			EV_BOOT: dur = 11'd1500;
			default: dur = '0;
		endcase
		return dur;
	endfunction

endpackage
`default_nettype wire

>>> sv/lsea_in_if.sv
`default_nettype none
interface lsea_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [lsea_pkg::KIND_W-1:0] event_kind;
	logic [lsea_pkg::TIME_W-1:0] now_ms;

	modport source(output valid, output operation, output event_kind, output now_ms,
		input ready);
	modport sink(input valid, input operation, input event_kind, input now_ms,
		output ready);
endinterface
`default_nettype wire

>>> sv/lsea_out_if.sv
`default_nettype none
interface lsea_out_if;
	logic valid;
	logic ready;
	logic [lsea_pkg::PIX_W-1:0] pixel_index;
	logic [lsea_pkg::COLOR_W-1:0] pixel_color;
	logic last_pixel;

	modport source(output valid, output pixel_index, output pixel_color, output last_pixel,
		input ready);
	modport sink(input valid, input pixel_index, input pixel_color, input last_pixel,
		output ready);
endinterface
`default_nettype wire

>>> sv/lsea_front.sv
`default_nettype none
module lsea_front (
	input logic clk,
	input logic arst_n,
	input logic led_enable,
	lsea_in_if.sink events,
	input lsea_pkg::q_stat_t q_stat,
	output logic push,
	output lsea_pkg::job_t push_job
);

	logic [lsea_pkg::TIME_W-1:0] last_frame_q;
	logic [lsea_pkg::TIME_W-1:0] start_q;
	logic running_q;
	lsea_pkg::kind_t kind_q;

	logic accept;
	logic [lsea_pkg::TIME_W-1:0] gap;
	logic [lsea_pkg::TIME_W-1:0] elapsed;
	logic [lsea_pkg::DUR_W-1:0] dur;
	logic tick_ok;
	logic expire;
	logic event_ok;

	assign events.ready = !q_stat.full;
	assign accept = events.valid && events.ready;

	assign gap = events.now_ms - last_frame_q;
	assign elapsed = events.now_ms - start_q;
	assign dur = lsea_pkg::event_duration(kind_q);

	assign tick_ok = accept && led_enable && (events.operation == lsea_pkg::OP_TICK)
		&& (gap >= lsea_pkg::FRAME_GAP_MS);
	assign expire = running_q && (dur != '0)
		&& (elapsed >= {{(lsea_pkg::TIME_W - lsea_pkg::DUR_W){1'b0}}, dur});
	assign event_ok = accept && led_enable && (events.operation == lsea_pkg::OP_EVENT)
		&& (events.event_kind <= lsea_pkg::EV_BOOT);

	assign push = tick_ok && !expire;
	assign push_job.run = running_q;
	assign push_job.kind = kind_q;
	assign push_job.dt = elapsed;
	assign push_job.now = events.now_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_frame_q <= '0;
			start_q <= '0;
			running_q <= 1'b0;
			kind_q <= lsea_pkg::EV_BOOT;
		end else begin
			if (event_ok) begin
				kind_q <= lsea_pkg::kind_t'(events.event_kind);
				start_q <= events.now_ms;
				running_q <= 1'b1;
			end
			if (tick_ok) begin
				last_frame_q <= events.now_ms;
				if (expire) begin
					running_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/lsea_queue.sv
`default_nettype none
module lsea_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lsea_pkg::job_t push_job,
	input logic pop,
	output lsea_pkg::job_t head_job,
	output lsea_pkg::q_stat_t q_stat
);

	lsea_pkg::job_t mem_q [lsea_pkg::QUEUE_DEPTH];
	logic [lsea_pkg::QPTR_W-1:0] wr_q;
	logic [lsea_pkg::QPTR_W-1:0] rd_q;
	logic [lsea_pkg::QCNT_W-1:0] count_q;

	assign head_job = mem_q[rd_q];
	assign q_stat.full = (count_q == lsea_pkg::QCNT_W'(lsea_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == lsea_pkg::QPTR_W'(lsea_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == lsea_pkg::QPTR_W'(lsea_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/lsea_back.sv
`default_nettype none
module lsea_back (
	input logic clk,
	input logic arst_n,
	input logic [lsea_pkg::COLOR_W-1:0] mood_color,
	input lsea_pkg::q_stat_t q_stat,
	input lsea_pkg::job_t head_job,
	output logic pop,
	lsea_out_if.source pixels
);

	typedef enum logic [5:0] {
		ST_WAIT = 6'b000001,
		ST_DIV = 6'b000010,
		ST_P1 = 6'b000100,
		ST_P2 = 6'b001000,
		ST_P3 = 6'b010000,
		ST_EMIT = 6'b100000
	} st_t;

	localparam int REM_HI_W = lsea_pkg::REM_W - 2;
	localparam int SR_PROD_W = REM_HI_W + 13;
	localparam int BK_PROD_W = lsea_pkg::REM_W + 3 + 16;
	localparam int BT_Z_W = lsea_pkg::TDT_W + lsea_pkg::BOOT_MUL_W;
	localparam int BT_PROD_W = BT_Z_W - 2 + 14;

	st_t st_q;
	lsea_pkg::job_t job_q;
	logic [lsea_pkg::TIME_W-1:0] opnd_q;
	logic [lsea_pkg::REM_W-1:0] rem_q;
	logic [lsea_pkg::DSTEP_W-1:0] step_q;
	logic [lsea_pkg::PIX_W-1:0] pix_q;

	logic cap_odd_q;
	logic de_odd_q;
	logic [14:0] fr_z_q;
	logic [17:0] fx_z_q;
	logic [BT_Z_W-1:0] bt_z_q;
	logic [lsea_pkg::PIX_W-1:0] sr_pos_q;
	logic [7:0] k_q;
	logic [7:0] fr_v_q;
	logic [7:0] fx_v_q;
	logic [lsea_pkg::HEAD_W-1:0] head_q;
	logic [7:0] lum_q;
	logic [lsea_pkg::COLOR_W-1:0] idle_color_q;

	logic out_valid_q;
	logic [lsea_pkg::PIX_W-1:0] out_index_q;
	logic [lsea_pkg::COLOR_W-1:0] out_color_q;
	logic out_last_q;

	logic needs_div;
	logic [lsea_pkg::REM_W-1:0] dvs;
	logic [lsea_pkg::REM_W-1:0] rem_nx;
	logic [lsea_pkg::TDT_W-1:0] dt_t;
	logic [18:0] cap_prod;
	logic [14:0] de_prod;
	logic [9:0] fr_a;
	logic [9:0] fx_a;
	logic [SR_PROD_W-1:0] sr_prod;
	logic [BK_PROD_W-1:0] bk_prod;
	logic [28:0] fr_prod;
	logic [30:0] fx_prod;
	logic [BT_PROD_W-1:0] bt_prod;
	logic [6:0] cos_idx;
	logic cos_neg;
	logic [5:0] cos_mag;
	logic [15:0] idle_r;
	logic [15:0] idle_g;
	logic [15:0] idle_b;
	logic [lsea_pkg::HEAD_W-1:0] pix_w;
	logic boot_side;
	logic last_now;
	logic out_load;
	logic [lsea_pkg::COLOR_W-1:0] color;

	assign pop = (st_q == ST_WAIT) && !q_stat.empty;
	assign needs_div = !head_job.run || (head_job.kind == lsea_pkg::EV_SEARCH);
	assign dvs = job_q.run ? lsea_pkg::SEARCH_DIV : lsea_pkg::BREATH_DIV;

	// Remainder unit: four restoring steps per cycle, MSB first.
	always_comb begin
		rem_nx = rem_q;
		for (int b = 0; b < lsea_pkg::DIV_BITS; b++) begin
			rem_nx = {rem_nx[lsea_pkg::REM_W-2:0], opnd_q[lsea_pkg::TIME_W-1-b]};
			if (rem_nx >= dvs) begin
				rem_nx = rem_nx - dvs;
			end
		end
	end

	// Timed animations always render with dt below their duration.
	assign dt_t = job_q.dt[lsea_pkg::TDT_W-1:0];
	assign cap_prod = 19'(dt_t[lsea_pkg::TDT_W-1:1]) * 19'(lsea_pkg::CAP_RECIP);
	assign de_prod = 15'(dt_t[lsea_pkg::TDT_W-1:4]) * 15'(lsea_pkg::DEAUTH_RECIP);
	assign fr_a = (dt_t < 11'd350) ? dt_t[9:0] : 10'(11'd700 - dt_t);
	assign fx_a = 10'(11'd1000 - dt_t);
	assign sr_prod = SR_PROD_W'(rem_q[lsea_pkg::REM_W-1:2]) * SR_PROD_W'(lsea_pkg::SEARCH_RECIP);
	assign bk_prod = BK_PROD_W'({rem_q, 3'b000}) * BK_PROD_W'(lsea_pkg::BREATH_RECIP);

	assign fr_prod = 29'(fr_z_q[14:1]) * 29'(lsea_pkg::FRIEND_RECIP);
	assign fx_prod = 31'(fx_z_q[17:3]) * 31'(lsea_pkg::FIX_RECIP);
	assign bt_prod = BT_PROD_W'(bt_z_q[BT_Z_W-1:2]) * BT_PROD_W'(lsea_pkg::BOOT_RECIP);

	always_comb begin
		if (k_q <= 8'd64) begin
			cos_idx = k_q[6:0];
			cos_neg = 1'b0;
		end else if (k_q <= 8'd128) begin
			cos_idx = 7'(8'd128 - k_q);
			cos_neg = 1'b1;
		end else if (k_q <= 8'd192) begin
			cos_idx = 7'(k_q - 8'd128);
			cos_neg = 1'b1;
		end else begin
			cos_idx = 7'(9'd256 - {1'b0, k_q});
			cos_neg = 1'b0;
		end
		cos_mag = lsea_pkg::COS_QUARTER[cos_idx];
	end

	assign idle_r = 16'(mood_color[23:16]) * 16'(lum_q);
	assign idle_g = 16'(mood_color[15:8]) * 16'(lum_q);
	assign idle_b = 16'(mood_color[7:0]) * 16'(lum_q);

	assign pix_w = {1'b0, pix_q};
	assign boot_side = (pix_w + 1'b1 == head_q) || (head_q + 1'b1 == pix_w);
	assign last_now = (pix_q == lsea_pkg::PIX_W'(lsea_pkg::LED_COUNT - 1));
	assign out_load = (st_q == ST_EMIT) && (!out_valid_q || pixels.ready);

	always_comb begin
		color = '0;
		if (!job_q.run) begin
			color = idle_color_q;
		end else begin
			case (job_q.kind)
				lsea_pkg::EV_CAPTURE: color = cap_odd_q ? '0 : lsea_pkg::COLOR_CAPTURE;
				lsea_pkg::EV_DEAUTH: color = (pix_q[0] == de_odd_q) ? lsea_pkg::COLOR_DEAUTH : '0;
				lsea_pkg::EV_FRIEND: color = {lsea_pkg::FRIEND_RED, lsea_pkg::FRIEND_GREEN, fr_v_q};
				lsea_pkg::EV_SEARCH: color = (pix_q == sr_pos_q) ? lsea_pkg::COLOR_SEARCH : '0;
				lsea_pkg::EV_FIX: color = {fx_v_q, fx_v_q, fx_v_q};
				lsea_pkg::EV_BOOT: begin
					if (pix_w == head_q) begin
						color = {lsea_pkg::BOOT_HEAD_RED, 16'd0};
					end else if (boot_side) begin
						color = {lsea_pkg::BOOT_SIDE_RED, 16'd0};
					end
				end
				default: color = '0;
			endcase
		end
	end

	assign pixels.valid = out_valid_q;
	assign pixels.pixel_index = out_index_q;
	assign pixels.pixel_color = out_color_q;
	assign pixels.last_pixel = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
			opnd_q <= head_job.run ? head_job.dt : head_job.now;
			rem_q <= '0;
		end
		if (st_q == ST_DIV) begin
			rem_q <= rem_nx;
			opnd_q <= opnd_q << lsea_pkg::DIV_BITS;
		end
		if (st_q == ST_P1) begin
			cap_odd_q <= cap_prod[lsea_pkg::CAP_SHIFT];
			de_odd_q <= de_prod[lsea_pkg::DEAUTH_SHIFT];
			fr_z_q <= 15'(fr_a) * 15'(51);
			fx_z_q <= 18'(fx_a) * 18'(255);
			bt_z_q <= BT_Z_W'(dt_t) * BT_Z_W'(lsea_pkg::BOOT_MUL);
			sr_pos_q <= sr_prod[lsea_pkg::SEARCH_SHIFT +: lsea_pkg::PIX_W];
			k_q <= bk_prod[lsea_pkg::BREATH_SHIFT +: 8];
		end
		if (st_q == ST_P2) begin
			fr_v_q <= fr_prod[lsea_pkg::FRIEND_SHIFT +: 8];
			fx_v_q <= fx_prod[lsea_pkg::FIX_SHIFT +: 8];
			head_q <= bt_prod[lsea_pkg::BOOT_SHIFT +: lsea_pkg::HEAD_W];
			lum_q <= cos_neg ? lsea_pkg::LUM_BASE + 8'(cos_mag) : lsea_pkg::LUM_BASE - 8'(cos_mag);
		end
		if (st_q == ST_P3) begin
			idle_color_q <= {idle_r[15:8], idle_g[15:8], idle_b[15:8]};
		end
		if (out_load) begin
			out_index_q <= pix_q;
			out_color_q <= color;
			out_last_q <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_WAIT;
			step_q <= '0;
			pix_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_WAIT: begin
					if (pop) begin
						step_q <= '0;
						st_q <= needs_div ? ST_DIV : ST_P1;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == lsea_pkg::DSTEP_W'(lsea_pkg::DIV_STEPS - 1)) begin
						st_q <= ST_P1;
					end
				end
				ST_P1: st_q <= ST_P2;
				ST_P2: st_q <= ST_P3;
				ST_P3: begin
					pix_q <= '0;
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						pix_q <= pix_q + 1'b1;
						if (last_now) begin
							st_q <= ST_WAIT;
						end
					end
				end
				default: st_q <= ST_WAIT;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/led_strip_event_animator.sv
// Channel   Direction  Transaction payload
// events    in         operation, event_kind, now_ms
// pixels    out        pixel_index, pixel_color, last_pixel
// cfg       in         cfg_we, cfg_index, cfg_wdata (write only)
//
// The front end takes one input transaction per cycle while the two-entry job queue has room.
// The back end renders a frame in steps P1, P2 and P3 and the emit sequencer, after its shared
// remainder unit (four bits per cycle) for idle breathing and gps searching frames.
// Events, dropped ticks and expiring ticks finish in the front end and emit nothing.
// A stalled pixel holds in the output register and halts the emit sequencer.
// Reset restores the enable, the mood color and the event state, and empties the queue.
`default_nettype none
`include "led_strip_event_animator_macros.svh"
module led_strip_event_animator (
	input logic clk,
	input logic arst_n,
	lsea_in_if.sink events,
	lsea_out_if.source pixels,
	input logic cfg_we,
	input logic [lsea_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lsea_pkg::COLOR_W-1:0] cfg_wdata
);

	logic led_enable_q;
	logic [lsea_pkg::COLOR_W-1:0] mood_color_q;
	logic push;
	logic pop;
	lsea_pkg::job_t push_job;
	lsea_pkg::job_t head_job;
	lsea_pkg::q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_enable_q <= 1'b1;
			mood_color_q <= lsea_pkg::MOOD_RESET;
		end else if (cfg_we) begin
			case (lsea_pkg::reg_t'(cfg_index))
				lsea_pkg::REG_LED_ENABLE: led_enable_q <= cfg_wdata[0];
				lsea_pkg::REG_MOOD_COLOR: mood_color_q <= cfg_wdata;
				default: led_enable_q <= led_enable_q;
			endcase
		end
	end

	lsea_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.led_enable(led_enable_q),
		.events(events),
		.q_stat(q_stat),
		.push(push),
		.push_job(push_job)
	);

	lsea_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head_job(head_job),
		.q_stat(q_stat)
	);

	lsea_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mood_color(mood_color_q),
		.q_stat(q_stat),
		.head_job(head_job),
		.pop(pop),
		.pixels(pixels)
	);

	`LSEA_ASSERT_IMPLY(a_no_push_when_full, q_stat.full, !push)
	`LSEA_ASSERT_IMPLY(a_no_push_when_disabled, !led_enable_q, !push)
	`LSEA_ASSERT_NEXT(a_push_fills_queue, q_stat.empty && push, !q_stat.empty)
	`LSEA_ASSERT_IMPLY(a_last_pixel_index, pixels.valid,
		pixels.last_pixel == (pixels.pixel_index ==
		lsea_pkg::PIX_W'(lsea_pkg::LED_COUNT - 1)))

endmodule
`default_nettype wire
